// ----- sv/mio0_pkg.sv -----
// mio0_pkg: shared types and constants for the MIO0 LZ decompressor.
// Token and byte beat structs, controller/datapath command and status bundles.
// No dependencies.
`default_nettype none

package mio0_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int BP_W         = 24;
    localparam int CNT_W        = 5;      // copy length 3..18
    localparam int DIST_W       = 13;     // distance 1..4096
    localparam int COPY_BIAS    = 3;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_ADDR_W-1:0] ADDR_OUTPUT_SIZE = 2'd0;

    typedef struct packed {
        logic        is_literal;
        logic [7:0]  literal_value;
        logic [3:0]  length_code;
        logic [11:0] distance_code;
    } token_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_token;
        logic       stream_done;
        logic       bad_distance;
    } byte_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic start;    // latch token, issue first history read
        logic emit;     // produce one byte into the output register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;     // bytes produced >= output size
        logic last;     // byte produced now ends the token
        logic out_free; // output register can take a byte this cycle
    } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/mio0_ctrl.sv -----
// mio0_ctrl: token sequencer for the MIO0 decompressor.
// Depends on mio0_pkg (ctl_cmd_t, dp_status_t).
`default_nettype none

module mio0_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 tok_is_literal,
    input  mio0_pkg::dp_status_t status,
    output mio0_pkg::ctl_cmd_t  cmd
);
    import mio0_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIT,
        S_COPY
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == S_IDLE);
    // a token that arrives after the stream is complete is taken and dropped
    assign cmd.start = in_valid && in_ready && !status.done;
    assign cmd.emit  = (state_reg != S_IDLE) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = tok_is_literal ? S_LIT : S_COPY;
                end
            end
            S_LIT:
            begin
                if (cmd.emit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_COPY:
            begin
                if (cmd.emit && status.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mio0_datapath.sv -----
// mio0_datapath: history window, counters, copy source pointer and output register.
// Depends on mio0_pkg; driven by mio0_ctrl through ctl_cmd_t.
`default_nettype none

module mio0_datapath (
    input  wire                            clk,
    input  wire                            rst_n,
    input  mio0_pkg::token_t               tok,
    input  wire [mio0_pkg::BP_W-1:0]       output_size,
    input  mio0_pkg::ctl_cmd_t             cmd,
    output mio0_pkg::dp_status_t           status,
    output logic                           out_valid,
    input  wire                            out_ready,
    output mio0_pkg::byte_beat_t           byte_beat
);
    import mio0_pkg::*;

    logic [7:0]        hist_mem [WINDOW_DEPTH];

    logic [BP_W-1:0]   bp_reg;
    logic [WIN_AW-1:0] wp_reg;
    logic              out_valid_reg;
    byte_beat_t        out_reg;

    logic              lit_reg;
    logic [7:0]        lit_val_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic              bad_reg;
    logic [WIN_AW-1:0] src_reg;
    logic [7:0]        rd_data_reg;
    logic              byp_reg;
    logic [7:0]        byp_data_reg;

    logic              rd_en;
    logic [WIN_AW-1:0] raddr;
    logic [BP_W-1:0]   bp_inc;
    logic [7:0]        hist_byte;
    logic              src_valid;
    logic [7:0]        byte_next;
    logic [DIST_W-1:0] dist_in;

    assign bp_inc    = bp_reg + BP_W'(1);
    assign dist_in   = {1'b0, tok.distance_code} + DIST_W'(1);

    // one read per byte; the next source address is issued as this byte is written
    assign rd_en     = cmd.start || (cmd.emit && !lit_reg);
    assign raddr     = cmd.start ? (wp_reg - tok.distance_code - WIN_AW'(1))
                                 : (src_reg + WIN_AW'(1));

    // distance-one copies read the byte written in the same cycle
    assign hist_byte = byp_reg ? byp_data_reg : rd_data_reg;
    assign src_valid = (bp_reg >= BP_W'(dist_reg));
    assign byte_next = lit_reg ? lit_val_reg : (src_valid ? hist_byte : 8'h00);

    assign status.done     = (bp_reg >= output_size);
    assign status.last     = (rem_reg == CNT_W'(1)) || (bp_inc >= output_size);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign byte_beat = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hist_mem[wp_reg] <= byte_next;
        end
        if (rd_en)
        begin
            rd_data_reg  <= hist_mem[raddr];
            byp_reg      <= cmd.emit && (raddr == wp_reg);
            byp_data_reg <= byte_next;
            src_reg      <= raddr;
        end
    end

    // token fields and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lit_reg     <= tok.is_literal;
            lit_val_reg <= tok.literal_value;
            dist_reg    <= dist_in;
            rem_reg     <= tok.is_literal ? CNT_W'(1)
                                          : CNT_W'(tok.length_code) + CNT_W'(COPY_BIAS);
            bad_reg     <= !tok.is_literal && (BP_W'(dist_in) > bp_reg);
        end
        else if (cmd.emit)
        begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
        if (cmd.emit)
        begin
            out_reg.out_byte      <= byte_next;
            out_reg.last_of_token <= status.last;
            out_reg.stream_done   <= (bp_inc >= output_size);
            out_reg.bad_distance  <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg        <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                bp_reg        <= bp_inc;
                wp_reg        <= wp_reg + WIN_AW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (bp_reg < output_size))
        else $error("byte produced past output size");

    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while stalled");

    a_done_ends_token: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.stream_done) |-> out_reg.last_of_token)
        else $error("stream_done without last_of_token");

    a_ptr_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg == bp_reg[WIN_AW-1:0])
        else $error("window pointer out of step with byte count");

endmodule

`default_nettype wire

// ----- sv/mio0_lz_decompressor.sv -----
// mio0_lz_decompressor: top level of the MIO0 LZ token decoder.
// Depends on mio0_pkg, mio0_ctrl, mio0_datapath.
//
// Usage:
//   in_valid/in_ready/in_data move one token beat (literal byte or
//   back-reference: length code+3 bytes, distance code+1 back).
//   out_valid/out_ready/byte_beat move one decompressed byte per beat, with
//   last_of_token on the token's final byte, stream_done on the byte that
//   reaches output_size, bad_distance on every byte of a reference that
//   reaches before the first output byte (those source bytes read as 0).
//   output_size is an APB register at address 0; write it while idle.
// Timing:
//   A token is taken only when the previous one has been fully handed to
//   the output register. A literal is accepted, then emitted; a
//   back-reference is accepted, then emits one byte per cycle while the output
//   register is free, through the single window read port with a write-to-read
//   bypass for distance-one copies. The first byte is emitted from the literal
//   or copy state entered on acceptance. Copies are clipped at output_size.
// Reset:
//   Byte count, window pointer and output_size clear; the window contents
//   are not cleared. With output_size 0 every token is accepted and dropped.
// Stall:
//   If out_ready is low the output register holds its byte and decoding
//   pauses; nothing is lost or repeated.
`default_nettype none

module mio0_lz_decompressor (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  mio0_pkg::token_t                     in_data,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output mio0_pkg::byte_beat_t                 byte_beat,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [mio0_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire [mio0_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [mio0_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import mio0_pkg::*;

    logic [BP_W-1:0] output_size_reg;
    ctl_cmd_t        cmd;
    dp_status_t      status;

    // APB register file: single size register, zero-wait
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_size_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_OUTPUT_SIZE))
        begin
            output_size_reg <= pwdata[BP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr)
            ADDR_OUTPUT_SIZE: prdata = CFG_DATA_W'(output_size_reg);
            default:          prdata = '0;
        endcase
    end

    mio0_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .tok_is_literal (in_data.is_literal),
        .status         (status),
        .cmd            (cmd)
    );

    mio0_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok         (in_data),
        .output_size (output_size_reg),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_beat   (byte_beat)
    );

endmodule

`default_nettype wire
